// File: hw/rtl/bmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants of the button menu page controller.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int PAGE_W = 3;
	localparam int MASK_W = 8;
	localparam int TIME_W = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 3;

	// item operations
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_FLASH = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_LONG_PRESS = 3'd1,
		REG_IDLE_RET   = 3'd2,
		REG_READY      = 3'd3,
		REG_DEMOD      = 3'd4,
		REG_START_MODE = 3'd5,
		REG_VIEW_LOCK  = 3'd6,
		REG_PIN_LOCK   = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic [15:0]       DEBOUNCE_RST   = 16'd30;
	localparam logic [15:0]       LONG_PRESS_RST = 16'd800;
	localparam logic [TIME_W-1:0] IDLE_RET_RST   = 32'd20000;
	localparam logic [MASK_W-1:0] READY_RST      = 8'h3F;
	localparam logic [MASK_W-1:0] DEMOD_RST      = 8'hF0;
	localparam logic [PAGE_W-1:0] START_MODE_RST = 3'd4;
	localparam logic [MASK_W-1:0] VIEW_LOCK_RST  = 8'h08;
	localparam logic [MASK_W-1:0] PIN_LOCK_RST   = 8'h30;
	localparam logic [PAGE_W-1:0] STATUS_PAGE    = 3'd0;

	typedef struct packed {
		logic [15:0]       debounce_ms;
		logic [15:0]       long_press_ms;
		logic [TIME_W-1:0] idle_return_ms;
		logic [MASK_W-1:0] ready_mask;
		logic [MASK_W-1:0] demod_mask;
		logic [MASK_W-1:0] view_lock_mask;
		logic [MASK_W-1:0] pin_lock_mask;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [TIME_W-1:0] now_ms;
		logic              button_pressed;
		logic [PAGE_W-1:0] flash_page;
		logic [TIME_W-1:0] hold_ms;
	} item_t;

	typedef struct packed {
		logic [PAGE_W-1:0] cur_page;
		logic [PAGE_W-1:0] cur_mode;
		logic              dirty_flag;
		logic              stable_level;
		logic              raw_level;
		logic [TIME_W-1:0] change_time;
		logic [TIME_W-1:0] down_time;
		logic              long_done;
		logic [TIME_W-1:0] activity_time;
		logic [TIME_W-1:0] hold_deadline;
		logic              pin_flag;
	} state_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [PAGE_W-1:0] mode;
		logic              dirty;
		logic              pinned;
		logic              page_ready;
		logic              short_press;
		logic              long_press;
	} result_t;

endpackage
`default_nettype wire

// File: hw/rtl/bmp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_cfg_regs
// Configuration register file, written through the config write channel.
// ----------------------------------------------------------------------------
module bmp_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [bmp_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [bmp_pkg::CFG_DATA_W-1:0]  wr_data,
	output bmp_pkg::cfg_t                        cfg
);
	import bmp_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms    <= DEBOUNCE_RST;
			cfg_q.long_press_ms  <= LONG_PRESS_RST;
			cfg_q.idle_return_ms <= IDLE_RET_RST;
			cfg_q.ready_mask     <= READY_RST;
			cfg_q.demod_mask     <= DEMOD_RST;
			cfg_q.view_lock_mask <= VIEW_LOCK_RST;
			cfg_q.pin_lock_mask  <= PIN_LOCK_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DEBOUNCE:   cfg_q.debounce_ms    <= wr_data[15:0];
				REG_LONG_PRESS: cfg_q.long_press_ms  <= wr_data[15:0];
				REG_IDLE_RET:   cfg_q.idle_return_ms <= wr_data[TIME_W-1:0];
				REG_READY:      cfg_q.ready_mask     <= wr_data[MASK_W-1:0];
				REG_DEMOD:      cfg_q.demod_mask     <= wr_data[MASK_W-1:0];
				// start mode only matters at reset, and reset restores it too
				REG_START_MODE: ;
				REG_VIEW_LOCK:  cfg_q.view_lock_mask <= wr_data[MASK_W-1:0];
				REG_PIN_LOCK:   cfg_q.pin_lock_mask  <= wr_data[MASK_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: hw/rtl/bmp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_step
// Next-state and result logic for one item: debounce, press handling,
// flash hold and inactivity return.
// ----------------------------------------------------------------------------
module bmp_step #(
	parameter int PAGE_COUNT = 8
) (
	input  wire bmp_pkg::state_t  cur,
	input  wire bmp_pkg::item_t   item,
	input  wire bmp_pkg::cfg_t    cfg,
	output bmp_pkg::state_t       nxt,
	output bmp_pkg::result_t      res
);
	import bmp_pkg::*;

	localparam logic [PAGE_W:0] PAGE_LIMIT = (PAGE_W+1)'(PAGE_COUNT);

	// switch to a page, restarting the inactivity timer
	function automatic state_t show_page(state_t s, logic [PAGE_W-1:0] p,
			logic [TIME_W-1:0] now);
		state_t r;
		r = s;
		if (p != s.cur_page) begin
			r.cur_page   = p;
			r.dirty_flag = 1'b1;
		end
		r.activity_time = now;
		return r;
	endfunction

	state_t            st;
	logic              sp;
	logic              lp;
	logic              locked;
	logic              active;
	logic [PAGE_W:0]   step_wide;
	logic [PAGE_W-1:0] step_page;
	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_down;
	logic [TIME_W-1:0] since_hold;
	logic [TIME_W-1:0] since_activity;

	always_comb begin
		st             = cur;
		sp             = 1'b0;
		lp             = 1'b0;
		locked         = 1'b0;
		active         = 1'b0;
		step_wide      = {1'b0, cur.cur_page} + 1'b1;
		step_page      = (step_wide >= PAGE_LIMIT) ? STATUS_PAGE : step_wide[PAGE_W-1:0];
		since_change   = item.now_ms - cur.change_time;
		since_down     = '0;
		since_hold     = '0;
		since_activity = '0;
		unique case (opcode_t'(item.opcode))
			OP_TICK: begin
				// debounce the raw level
				if (item.button_pressed != st.raw_level) begin
					st.raw_level   = item.button_pressed;
					st.change_time = item.now_ms;
				end else if (since_change >= {16'd0, cfg.debounce_ms}
						&& item.button_pressed != st.stable_level) begin
					st.stable_level = item.button_pressed;
					if (item.button_pressed) begin
						st.down_time = item.now_ms;
						st.long_done = 1'b0;
					end else if (!st.long_done) begin
						// short press: step to the next page
						st     = show_page(st, step_page, item.now_ms);
						active = cfg.demod_mask[step_page] & cfg.ready_mask[step_page];
						if (active) begin
							st.cur_mode = step_page;
						end
						st.hold_deadline = '0;
						st.pin_flag      = active;
						sp               = 1'b1;
					end
				end
				// long press fires while held
				since_down = item.now_ms - st.down_time;
				if (st.stable_level && !st.long_done
						&& since_down >= {16'd0, cfg.long_press_ms}) begin
					st.long_done = 1'b1;
					st.cur_mode  = STATUS_PAGE;
					st.pin_flag  = 1'b0;
					st           = show_page(st, STATUS_PAGE, item.now_ms);
					lp           = 1'b1;
				end
				locked = (st.pin_flag & cfg.pin_lock_mask[st.cur_page])
					| cfg.view_lock_mask[st.cur_page];
				// flash hold expiry, signed wrap compare
				since_hold = item.now_ms - st.hold_deadline;
				if (st.hold_deadline != '0 && !since_hold[TIME_W-1]) begin
					st.hold_deadline = '0;
					if (!locked) begin
						st = show_page(st, STATUS_PAGE, item.now_ms);
					end
				end
				// inactivity return
				since_activity = item.now_ms - st.activity_time;
				if (st.hold_deadline == '0 && st.cur_page != STATUS_PAGE && !locked
						&& since_activity >= cfg.idle_return_ms) begin
					st = show_page(st, STATUS_PAGE, item.now_ms);
				end
			end
			OP_FLASH: begin
				if (st.cur_mode == item.flash_page) begin
					st               = show_page(st, item.flash_page, item.now_ms);
					st.hold_deadline = item.now_ms + item.hold_ms;
				end
			end
			OP_CLEAR: begin
				st.dirty_flag = 1'b0;
			end
			OP_NONE: ;
		endcase
	end

	assign nxt = st;

	// result from the updated state
	assign res.page        = st.cur_page;
	assign res.mode        = st.cur_mode;
	assign res.dirty       = st.dirty_flag;
	assign res.pinned      = st.pin_flag;
	assign res.page_ready  = cfg.ready_mask[st.cur_page];
	assign res.short_press = sp;
	assign res.long_press  = lp;

endmodule
`default_nettype wire

// File: hw/rtl/button_menu_page_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_menu_page_controller
// Button-driven menu page controller with debounce, short and long press,
// flash hold and inactivity return to the status page.
// ----------------------------------------------------------------------------
// Takes one item per clock while results are drained, and gives one result per
// item: the item is registered, then the step logic computes the new controller
// state and the result in one pass, which load the state registers and the
// result register at the same edge. The next item sees that state at once, so
// items stream at full rate; a stalled result holds one item in the input
// register and drops in_ready only when both registers are full.
// Configuration writes are always accepted; start_mode takes effect only
// through its reset value.
module button_menu_page_controller #(
	parameter int PAGE_COUNT = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input items
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      opcode,
	input  wire logic [bmp_pkg::TIME_W-1:0]      now_ms,
	input  wire logic                            button_pressed,
	input  wire logic [bmp_pkg::PAGE_W-1:0]      flash_page,
	input  wire logic [bmp_pkg::TIME_W-1:0]      hold_ms,
	// result items
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [bmp_pkg::PAGE_W-1:0]           page,
	output logic [bmp_pkg::PAGE_W-1:0]           mode,
	output logic                                 dirty,
	output logic                                 pinned,
	output logic                                 page_ready,
	output logic                                 short_press,
	output logic                                 long_press,
	// configuration writes
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bmp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bmp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bmp_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_take;

	assign cfg_ready = 1'b1;

	bmp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bmp_step #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// flow control between input and result registers
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign in_take  = in_valid & in_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.opcode         <= opcode;
			item_s1.now_ms         <= now_ms;
			item_s1.button_pressed <= button_pressed;
			item_s1.flash_page     <= flash_page;
			item_s1.hold_ms        <= hold_ms;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cur_page      <= STATUS_PAGE;
			state_q.cur_mode      <= START_MODE_RST;
			state_q.dirty_flag    <= 1'b1;
			state_q.stable_level  <= 1'b0;
			state_q.raw_level     <= 1'b0;
			state_q.change_time   <= '0;
			state_q.down_time     <= '0;
			state_q.long_done     <= 1'b0;
			state_q.activity_time <= '0;
			state_q.hold_deadline <= '0;
			state_q.pin_flag      <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign page        = res_s2.page;
	assign mode        = res_s2.mode;
	assign dirty       = res_s2.dirty;
	assign pinned      = res_s2.pinned;
	assign page_ready  = res_s2.page_ready;
	assign short_press = res_s2.short_press;
	assign long_press  = res_s2.long_press;

endmodule
`default_nettype wire

// File: hw/rtl/bmp_port_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_port_checker
// Port-level checks of the button menu page controller, bound to the top.
// ----------------------------------------------------------------------------
module bmp_port_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [bmp_pkg::PAGE_W-1:0] page,
	input wire logic [bmp_pkg::PAGE_W-1:0] mode,
	input wire logic                       dirty,
	input wire logic                       pinned,
	input wire logic                       short_press,
	input wire logic                       long_press
);
	import bmp_pkg::*;

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a release cannot be a short and a long press at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(short_press && long_press))
		else $error("short and long press in one item");

	// long press stops the mode and shows the status page
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && long_press |-> page == STATUS_PAGE && mode == STATUS_PAGE && !pinned)
		else $error("long press did not return to status");

	// a short press changes page when PAGE_COUNT is above one, so the page is dirty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && short_press |-> dirty)
		else $error("short press left page clean");

endmodule

bind button_menu_page_controller bmp_port_checker u_port_checker (.*);
`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button menu page controller. A queue-fed driver
// sends ticks, flash requests, dirty-clears and no-ops, mostly as press and
// release gestures with timing drawn around the debounce, long press and idle
// limits. A predictor tracks the controller state and register settings and
// forms the expected status for every accepted item. A monitor checks each
// result, field by field, against the oldest expected status.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmp_pkg::*;

	localparam int PAGES = 8;
	localparam int N_PHASE = 7;
	localparam int PHASE_ITEMS = 235;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [PAGE_W-1:0] MODE_STOPPED = 3'd0;

	logic clk;
	logic arst_n;

	logic in_valid;
	logic in_ready;
	logic [1:0] opcode;
	logic [TIME_W-1:0] now_ms;
	logic button_pressed;
	logic [PAGE_W-1:0] flash_page;
	logic [TIME_W-1:0] hold_ms;

	logic out_valid;
	logic out_ready;
	logic [PAGE_W-1:0] page;
	logic [PAGE_W-1:0] mode;
	logic dirty;
	logic pinned;
	logic page_ready;
	logic short_press;
	logic long_press;

	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor copy of controller state and registers
	state_t ctl;
	cfg_t regs;
	logic [PAGE_W-1:0] boot_mode;

	item_t item_backlog[$];
	item_t on_port;
	result_t due_status[$];
	result_t want;

	logic [TIME_W-1:0] clock_ms;
	bit calm;
	int n_err;
	int n_fed;
	int n_items;
	int n_results;
	int n_short;
	int n_long;
	int n_writes;
	int quiet_cycles;

	button_menu_page_controller #(
		.PAGE_COUNT(PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.now_ms(now_ms),
		.button_pressed(button_pressed),
		.flash_page(flash_page),
		.hold_ms(hold_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.page(page),
		.mode(mode),
		.dirty(dirty),
		.pinned(pinned),
		.page_ready(page_ready),
		.short_press(short_press),
		.long_press(long_press),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always #5 clk = ~clk;

	// page change with dirty tracking, also marks activity
	function automatic void show_page(logic [PAGE_W-1:0] pg, logic [TIME_W-1:0] t);
		if (pg != ctl.cur_page) begin
			ctl.cur_page = pg;
			ctl.dirty_flag = 1'b1;
		end
		ctl.activity_time = t;
	endfunction

	// next controller state and status for one item
	function automatic result_t predict_status(item_t it);
		result_t r;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] since;
		logic locked;
		logic active;
		int unsigned nxt;
		t = it.now_ms;
		r.short_press = 1'b0;
		r.long_press = 1'b0;
		case (opcode_t'(it.opcode))
			OP_TICK: begin
				// debounce, short press acts on release
				if (it.button_pressed != ctl.raw_level) begin
					ctl.raw_level = it.button_pressed;
					ctl.change_time = t;
				end else begin
					since = t - ctl.change_time;
					if (since >= 32'(regs.debounce_ms) &&
							it.button_pressed != ctl.stable_level) begin
						ctl.stable_level = it.button_pressed;
						if (it.button_pressed) begin
							ctl.down_time = t;
							ctl.long_done = 1'b0;
						end else if (!ctl.long_done) begin
							nxt = ctl.cur_page + 1;
							if (nxt >= PAGES)
								nxt = 0;
							show_page(3'(nxt), t);
							active = regs.demod_mask[nxt] & regs.ready_mask[nxt];
							if (active)
								ctl.cur_mode = 3'(nxt);
							ctl.hold_deadline = '0;
							ctl.pin_flag = active;
							r.short_press = 1'b1;
						end
					end
				end
				// long press fires while held
				since = t - ctl.down_time;
				if (ctl.stable_level && !ctl.long_done && since >= 32'(regs.long_press_ms)) begin
					ctl.long_done = 1'b1;
					ctl.cur_mode = MODE_STOPPED;
					ctl.pin_flag = 1'b0;
					show_page(STATUS_PAGE, t);
					r.long_press = 1'b1;
				end
				locked = (ctl.pin_flag & regs.pin_lock_mask[ctl.cur_page]) |
					regs.view_lock_mask[ctl.cur_page];
				// hold expiry uses a signed compare
				since = t - ctl.hold_deadline;
				if (ctl.hold_deadline != '0 && !since[TIME_W-1]) begin
					ctl.hold_deadline = '0;
					if (!locked)
						show_page(STATUS_PAGE, t);
				end
				// inactivity return
				since = t - ctl.activity_time;
				if (ctl.hold_deadline == '0 && ctl.cur_page != STATUS_PAGE && !locked &&
						since >= regs.idle_return_ms)
					show_page(STATUS_PAGE, t);
			end
			OP_FLASH: begin
				if (ctl.cur_mode == it.flash_page) begin
					show_page(it.flash_page, t);
					ctl.hold_deadline = t + it.hold_ms;
				end
			end
			OP_CLEAR: ctl.dirty_flag = 1'b0;
			OP_NONE: ;
		endcase
		r.page = ctl.cur_page;
		r.mode = ctl.cur_mode;
		r.dirty = ctl.dirty_flag;
		r.pinned = ctl.pin_flag;
		r.page_ready = regs.ready_mask[ctl.cur_page];
		return r;
	endfunction

	task automatic push_item(opcode_t op, logic [TIME_W-1:0] t, logic bp,
			logic [PAGE_W-1:0] fp, logic [TIME_W-1:0] hold);
		item_t it;
		it.opcode = op;
		it.now_ms = t;
		it.button_pressed = bp;
		it.flash_page = fp;
		it.hold_ms = hold;
		item_backlog.push_back(it);
		if (op != OP_NONE)
			n_fed++;
	endtask

	// time step drawn around the current debounce, long press and idle limits
	function automatic logic [TIME_W-1:0] pick_gap(int unsigned top);
		logic [TIME_W-1:0] dbn;
		dbn = 32'(regs.debounce_ms);
		case ($urandom_range(top))
			0, 1, 2: return (dbn == '0) ? '0 : $urandom_range(dbn - 1);
			3, 4, 5: return dbn + $urandom_range(3);
			6, 7: return 32'(regs.long_press_ms) + $urandom_range(50);
			8: return regs.idle_return_ms + $urandom_range(50);
			default: return $urandom;
		endcase
	endfunction

	task automatic push_tick(logic lvl, int unsigned top);
		clock_ms += pick_gap(top);
		push_item(OP_TICK, clock_ms, lvl, 3'($urandom), $urandom);
	endtask

	// one gesture or event with random content
	task automatic gen_burst();
		int unsigned pick;
		int unsigned top;
		logic [PAGE_W-1:0] fp;
		logic [TIME_W-1:0] hold;
		pick = $urandom_range(99);
		if (pick < 45) begin
			// press then release, sometimes held long, sometimes bouncing
			top = ($urandom_range(9) < 7) ? 5 : 9;
			push_tick(1'b1, top);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(99) < 10)
					push_tick(1'b0, 2);
				push_tick(1'b1, top);
			end
			repeat ($urandom_range(1, 3))
				push_tick(1'b0, 5);
		end else if (pick < 62) begin
			// flash, mostly of the running mode
			fp = ($urandom_range(3) != 0) ? ctl.cur_mode : 3'($urandom);
			clock_ms += pick_gap(5);
			case ($urandom_range(3))
				0: hold = pick_gap(8);
				1: hold = 32'd0 - clock_ms;
				2: hold = $urandom;
				default: hold = '0;
			endcase
			push_item(OP_FLASH, clock_ms, 1'($urandom), fp, hold);
			repeat ($urandom_range(2))
				push_tick(1'b0, 9);
		end else if (pick < 75) begin
			repeat ($urandom_range(1, 3))
				push_tick(1'b0, 9);
		end else if (pick < 85) begin
			push_item(OP_CLEAR, clock_ms, 1'($urandom), 3'($urandom), $urandom);
		end else if (pick < 88) begin
			push_item(OP_NONE, $urandom, 1'($urandom), 3'($urandom), $urandom);
		end else begin
			push_item(opcode_t'($urandom_range(3)), $urandom, 1'($urandom),
				3'($urandom), $urandom);
		end
	endtask

	// wait until nothing is queued, in flight or expected
	task automatic settle();
		while (item_backlog.size() != 0 || in_valid || due_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;
		case (idx)
			REG_DEBOUNCE: regs.debounce_ms = val[15:0];
			REG_LONG_PRESS: regs.long_press_ms = val[15:0];
			REG_IDLE_RET: regs.idle_return_ms = val;
			REG_READY: regs.ready_mask = val[MASK_W-1:0];
			REG_DEMOD: regs.demod_mask = val[MASK_W-1:0];
			REG_START_MODE: boot_mode = val[PAGE_W-1:0];
			REG_VIEW_LOCK: regs.view_lock_mask = val[MASK_W-1:0];
			REG_PIN_LOCK: regs.pin_lock_mask = val[MASK_W-1:0];
		endcase
	endtask

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				due_status.push_back(predict_status(on_port));
				n_items++;
			end
			if (!in_valid || in_ready) begin
				if (item_backlog.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
					on_port = item_backlog.pop_front();
					opcode <= on_port.opcode;
					now_ms <= on_port.now_ms;
					button_pressed <= on_port.button_pressed;
					flash_page <= on_port.flash_page;
					hold_ms <= on_port.hold_ms;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			n_err++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_results++;
				if (due_status.size() == 0) begin
					$error("result item with no expected status waiting");
					n_err++;
				end else begin
					want = due_status.pop_front();
					check_field("page", want.page, page);
					check_field("mode", want.mode, mode);
					check_field("dirty", want.dirty, dirty);
					check_field("pinned", want.pinned, pinned);
					check_field("page_ready", want.page_ready, page_ready);
					check_field("short_press", want.short_press, short_press);
					check_field("long_press", want.long_press, long_press);
					if (want.short_press)
						n_short++;
					if (want.long_press)
						n_long++;
				end
			end
			out_ready <= calm || ($urandom_range(99) >= 33);
		end
	end

	// count cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_top: errors");
		$finish;
	end

	// stimulus and register settings
	initial begin
		logic [CFG_DATA_W-1:0] plan [N_PHASE][8];
		int phase;
		int r;
		int fed_mark;
		bit paused;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_NONE;
		now_ms = '0;
		button_pressed = 1'b0;
		flash_page = '0;
		hold_ms = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		paused = 1'b0;
		quiet_cycles = 0;

		// state after reset
		regs.debounce_ms = DEBOUNCE_RST;
		regs.long_press_ms = LONG_PRESS_RST;
		regs.idle_return_ms = IDLE_RET_RST;
		regs.ready_mask = READY_RST;
		regs.demod_mask = DEMOD_RST;
		regs.view_lock_mask = VIEW_LOCK_RST;
		regs.pin_lock_mask = PIN_LOCK_RST;
		boot_mode = START_MODE_RST;
		ctl = '0;
		ctl.cur_page = STATUS_PAGE;
		ctl.cur_mode = START_MODE_RST;
		ctl.dirty_flag = 1'b1;

		// register settings per phase, phase 0 keeps reset values
		plan[1] = '{32'd5, 32'd200, 32'd3000, 32'hFF, 32'hFF, 32'd7, 32'h00, 32'hFF};
		plan[2] = '{32'd0, 32'd0, 32'd0, 32'h00, 32'h00, 32'd0, 32'h00, 32'h00};
		plan[3] = '{32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFF, 32'hFF, 32'd7, 32'hFF, 32'hFF};
		for (phase = 4; phase < 6; phase++) begin
			plan[phase][REG_DEBOUNCE] = $urandom_range(200);
			plan[phase][REG_LONG_PRESS] = $urandom_range(2000);
			plan[phase][REG_IDLE_RET] = $urandom_range(50000);
			plan[phase][REG_READY] = $urandom;
			plan[phase][REG_DEMOD] = $urandom;
			plan[phase][REG_START_MODE] = $urandom;
			plan[phase][REG_VIEW_LOCK] = $urandom;
			plan[phase][REG_PIN_LOCK] = $urandom;
		end
		plan[6] = '{32'(DEBOUNCE_RST), 32'(LONG_PRESS_RST), IDLE_RET_RST, 32'(READY_RST),
			32'(DEMOD_RST), 32'(START_MODE_RST), 32'(VIEW_LOCK_RST), 32'(PIN_LOCK_RST)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset status, short press, idle return, flash cases, long press
		push_item(OP_NONE, 32'd0, 1'b0, 3'd0, 32'd0);
		push_item(OP_CLEAR, 32'd0, 1'b0, 3'd0, 32'd0);
		push_item(OP_TICK, 32'd100, 1'b1, 3'd0, 32'd0);
		push_item(OP_TICK, 32'd140, 1'b1, 3'd0, 32'd0);
		push_item(OP_TICK, 32'd300, 1'b0, 3'd0, 32'd0);
		push_item(OP_TICK, 32'd340, 1'b0, 3'd0, 32'd0);
		push_item(OP_TICK, 32'd20340, 1'b0, 3'd0, 32'd0);
		push_item(OP_FLASH, 32'd20400, 1'b0, START_MODE_RST, 32'd500);
		push_item(OP_TICK, 32'd20950, 1'b0, 3'd0, 32'd0);
		// flash of a page that is not running
		push_item(OP_FLASH, 32'd21000, 1'b0, 3'd2, 32'd10);
		// deadline wraps to zero, so no hold
		push_item(OP_FLASH, 32'hFFFF_FF00, 1'b0, START_MODE_RST, 32'h100);
		push_item(OP_TICK, 32'hFFFF_FF10, 1'b0, 3'd0, 32'd0);
		push_item(OP_TICK, 32'h20, 1'b1, 3'd0, 32'd0);
		push_item(OP_TICK, 32'h50, 1'b1, 3'd0, 32'd0);
		push_item(OP_TICK, 32'h370, 1'b1, 3'd0, 32'd0);
		push_item(OP_TICK, 32'h400, 1'b0, 3'd0, 32'd0);
		// release after a long press does not page
		push_item(OP_TICK, 32'h440, 1'b0, 3'd0, 32'd0);
		push_item(OP_FLASH, 32'h500, 1'b0, MODE_STOPPED, 32'hFFFF_FFFF);
		push_item(OP_TICK, 32'h600, 1'b0, 3'd0, 32'd0);
		push_item(OP_NONE, 32'hFFFF_FFFF, 1'b1, 3'd7, 32'hFFFF_FFFF);
		push_item(OP_FLASH, 32'hFFFF_FFFF, 1'b1, 3'd7, 32'd0);
		clock_ms = 32'h1000;

		for (phase = 0; phase < N_PHASE; phase++) begin
			if (phase != 0) begin
				settle();
				for (r = 0; r < 8; r++)
					write_reg(reg_idx_t'(r), plan[phase][r]);
				clock_ms = $urandom;
			end
			calm = (phase == 1);
			fed_mark = n_fed;
			while (n_fed - fed_mark < PHASE_ITEMS) begin
				// sender holds off once until all results are in
				if (phase == 0 && !paused && n_fed - fed_mark > PHASE_ITEMS / 2) begin
					settle();
					paused = 1'b1;
				end
				while (item_backlog.size() >= 4)
					@(posedge clk);
				gen_burst();
				if (calm && n_fed - fed_mark > 200)
					calm = 1'b0;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("summary: %0d items and %0d results over %0d register settings (%0d writes)",
			n_items, n_results, N_PHASE, n_writes);
		$display("summary: %0d short presses and %0d long presses predicted", n_short, n_long);
		if (n_err == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
